// ----- hdl/mef_pkg.sv -----
// ----------------------------------------------------------------------------
// Mouse event motion filter package
// Shared constants, event codes and the controller state type.
// ----------------------------------------------------------------------------
package mef_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int WSIZE_W        = 6;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_MA      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

    localparam logic [16:0]        ONE_Q16       = 17'd65536;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET   = 6'd5;

    localparam logic [15:0] TYPE_SYN      = 16'd0;
    localparam logic [15:0] TYPE_KEY      = 16'd1;
    localparam logic [15:0] TYPE_REL      = 16'd2;
    localparam logic [15:0] CODE_LEFT     = 16'd272;
    localparam logic [15:0] CODE_RIGHT    = 16'd273;
    localparam logic [15:0] CODE_KP_MINUS = 16'd74;
    localparam logic [15:0] CODE_KP_PLUS  = 16'd78;
    localparam logic [15:0] CODE_REL_X    = 16'd0;
    localparam logic [15:0] CODE_REL_Y    = 16'd1;
    localparam logic [15:0] CODE_REL_Z    = 16'd2;
    localparam logic [15:0] CODE_WHEEL    = 16'd8;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_CURSOR = 3'd1,
        KIND_WHEEL  = 3'd2,
        KIND_LEFT   = 3'd3,
        KIND_RIGHT  = 3'd4,
        KIND_BTN_A  = 3'd5,
        KIND_BTN_B  = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WIN_RD,
        ST_WIN_POP,
        ST_WIN_PUSH,
        ST_SEL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LP_D,
        ST_LP_LO,
        ST_LP_HI,
        ST_LP_ADD,
        ST_LP_OUT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

endpackage

// ----- hdl/mouse_event_motion_filter.sv -----
// ----------------------------------------------------------------------------
// Mouse event motion filter
// Decodes mouse events and gives one report per frame with smoothed motion.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | has_event, event_type, event_code, value
//  output   | out_valid/out_stall | kind, button, motion x/y/z, wheel, smooth
//  config   | cfg_we              | cfg_index, cfg_data
//
//  An event that ends no frame is taken without leaving the idle state. A report
//  holds in_stall high through the window update and then, in low-pass mode,
//  the D, LO, HI, ADD and OUT steps per axis on multipliers shared by all axes,
//  or in moving-average mode the serial dividers; an empty window skips them.
//  Window samples live in one RAM; a pop reads the RAM before the update step.
//  Reset clears all control state; the window RAM needs no clearing.
//  A waiting report holds in the output register while the next event enters.
module mouse_event_motion_filter #(
    parameter int WINDOW_MAX = mef_pkg::WINDOW_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             has_event,
    input  logic [15:0]                      event_type,
    input  logic [15:0]                      event_code,
    input  logic signed [31:0]               event_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       event_kind,
    output logic signed [31:0]               button_state,
    output logic signed [31:0]               motion_x,
    output logic signed [31:0]               motion_y,
    output logic signed [31:0]               motion_z,
    output logic signed [31:0]               wheel_motion,
    output logic signed [39:0]               smooth_x,
    output logic signed [39:0]               smooth_y,
    output logic signed [39:0]               smooth_z,
    input  logic                             cfg_we,
    input  logic [mef_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mef_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import mef_pkg::*;

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 32 + ((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0);
    localparam int DW = SW + 8;
    localparam int CW = (FW > WSIZE_W) ? FW : WSIZE_W;

    // Configuration
    logic [16:0]        alpha_reg;
    logic               use_ma_reg;
    logic [WSIZE_W-1:0] wsize_reg;

    // Frame decode state
    kind_t              kind_reg, kind_next;
    logic signed [31:0] button_reg, button_next;
    logic signed [31:0] raw_x_reg, raw_x_next;
    logic signed [31:0] raw_y_reg, raw_y_next;
    logic signed [31:0] raw_z_reg, raw_z_next;
    logic signed [31:0] wheel_reg, wheel_next;
    logic               frame_reg, frame_next;
    logic               report_next;

    // Window and filter state
    logic [FW-1:0]      fill_reg;
    logic [IW-1:0]      oldest_reg;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg;
    logic signed [39:0] smooth_x_reg, smooth_y_reg, smooth_z_reg;
    logic               push_reg;
    axis_t              ax_reg;
    logic signed [40:0] d_reg;
    logic [40:0]        pl_reg;
    logic signed [34:0] ph_reg;
    logic signed [57:0] acc_reg;
    logic               neg_x_reg, neg_y_reg;

    // Output register
    logic               out_valid_reg;
    logic [2:0]         out_kind_reg;
    logic signed [31:0] out_button_reg, out_x_reg, out_y_reg, out_z_reg, out_wheel_reg;
    logic signed [39:0] out_sx_reg, out_sy_reg, out_sz_reg;

    state_t             state_reg, state_next;

    logic               in_accept;
    logic               out_free;
    logic [FW-1:0]      wsat;
    logic [CW-1:0]      ws_ext;
    logic [FW:0]        push_sum;
    logic [IW-1:0]      push_addr;
    logic [IW-1:0]      oldest_inc;
    logic               ram_we, ram_re;
    logic [63:0]        ram_rdata;
    logic               div_start;
    logic               busy_x, busy_y;
    logic [DW-1:0]      quo_x, quo_y;
    logic [SW-1:0]      mag_x, mag_y;
    logic [DW-1:0]      dvd_x, dvd_y;
    logic [39:0]        qx40, qy40;
    logic [16:0]        a_sat;
    logic signed [39:0] old_sel;
    logic signed [31:0] raw_sel;
    logic signed [39:0] raw256;
    logic [40:0]        pl_next;
    logic signed [34:0] ph_next;
    logic signed [39:0] lp_out;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= '0;
            use_ma_reg <= 1'b0;
            wsize_reg  <= WSIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA:       alpha_reg  <= cfg_data;
                CFG_USE_MA:      use_ma_reg <= cfg_data[0];
                CFG_WINDOW_SIZE: wsize_reg  <= cfg_data[WSIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Event decode
    always_comb
    begin
        kind_next   = kind_reg;
        button_next = button_reg;
        raw_x_next  = raw_x_reg;
        raw_y_next  = raw_y_reg;
        raw_z_next  = raw_z_reg;
        wheel_next  = wheel_reg;
        frame_next  = frame_reg;
        report_next = 1'b0;
        if (!has_event)
        begin
            kind_next   = KIND_NONE;
            report_next = 1'b1;
        end
        else
        begin
            case (event_type)
                TYPE_KEY:
                begin
                    case (event_code)
                        CODE_RIGHT:    kind_next = KIND_RIGHT;
                        CODE_LEFT:     kind_next = KIND_LEFT;
                        CODE_KP_MINUS: kind_next = KIND_BTN_B;
                        CODE_KP_PLUS:  kind_next = KIND_BTN_A;
                        default:       ;
                    endcase
                    button_next = event_value;
                end
                TYPE_REL:
                begin
                    case (event_code)
                        CODE_REL_X:
                        begin
                            kind_next  = KIND_CURSOR;
                            raw_x_next = event_value;
                            raw_y_next = '0;
                            frame_next = 1'b1;
                        end
                        CODE_REL_Y:
                        begin
                            kind_next  = KIND_CURSOR;
                            raw_y_next = event_value;
                            if (!frame_reg)
                            begin
                                raw_x_next = '0;
                                frame_next = 1'b1;
                            end
                        end
                        CODE_REL_Z:
                        begin
                            kind_next  = KIND_CURSOR;
                            raw_z_next = event_value;
                            if (!frame_reg)
                            begin
                                raw_x_next = '0;
                                raw_y_next = '0;
                                frame_next = 1'b1;
                            end
                        end
                        CODE_WHEEL:
                        begin
                            kind_next  = KIND_WHEEL;
                            wheel_next = event_value;
                        end
                        default: ;
                    endcase
                end
                TYPE_SYN: report_next = 1'b1;
                default:  ;
            endcase
        end
        if (report_next)
        begin
            frame_next = 1'b0;
        end
    end

    // Window arithmetic
    assign ws_ext     = CW'(wsize_reg);
    assign wsat       = (ws_ext > CW'(WINDOW_MAX)) ? FW'(WINDOW_MAX) : FW'(wsize_reg);
    assign push_sum   = (FW + 1)'(oldest_reg) + (FW + 1)'(fill_reg);
    assign push_addr  = (push_sum >= (FW + 1)'(WINDOW_MAX)) ?
                        IW'(push_sum - (FW + 1)'(WINDOW_MAX)) : IW'(push_sum);
    assign oldest_inc = (oldest_reg == IW'(WINDOW_MAX - 1)) ? '0 : IW'(oldest_reg + 1'b1);

    mef_ram #(
        .WIDTH (64),
        .DEPTH (WINDOW_MAX),
        .AW    (IW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (push_addr),
        .wdata ({raw_y_reg, raw_x_reg}),
        .re    (ram_re),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    // Moving average division with rounding to nearest, ties away from zero
    assign mag_x = sum_x_reg[SW-1] ? SW'(-sum_x_reg) : SW'(sum_x_reg);
    assign mag_y = sum_y_reg[SW-1] ? SW'(-sum_y_reg) : SW'(sum_y_reg);
    assign dvd_x = {mag_x, 8'd0} + DW'(fill_reg >> 1);
    assign dvd_y = {mag_y, 8'd0} + DW'(fill_reg >> 1);
    assign qx40  = quo_x[39:0];
    assign qy40  = quo_y[39:0];

    mef_div #(
        .DW (DW),
        .VW (FW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (fill_reg),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    mef_div #(
        .DW (DW),
        .VW (FW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (fill_reg),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // Low-pass: new = raw256 + floor((a * (old - raw256) + 2^15) / 2^16)
    assign a_sat = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;

    always_comb
    begin
        case (ax_reg)
            AX_X:
            begin
                old_sel = smooth_x_reg;
                raw_sel = raw_x_reg;
            end
            AX_Y:
            begin
                old_sel = smooth_y_reg;
                raw_sel = raw_y_reg;
            end
            default:
            begin
                old_sel = smooth_z_reg;
                raw_sel = raw_z_reg;
            end
        endcase
    end

    assign raw256  = $signed({raw_sel, 8'd0});
    assign pl_next = a_sat * d_reg[23:0];
    assign ph_next = $signed({1'b0, a_sat}) * $signed(d_reg[40:24]);
    assign lp_out  = raw256 + $signed(acc_reg[55:16]);

    // Controller: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && report_next)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (kind_reg != KIND_CURSOR)
                begin
                    state_next = ST_SEL;
                end
                else if (fill_reg > wsat)
                begin
                    state_next = ST_WIN_RD;
                end
                else if (fill_reg < wsat)
                begin
                    state_next = ST_WIN_PUSH;
                end
                else if (fill_reg != '0)
                begin
                    state_next = ST_WIN_RD;
                end
                else
                begin
                    state_next = ST_SEL;
                end
            end
            ST_WIN_RD:   state_next = ST_WIN_POP;
            ST_WIN_POP:  state_next = push_reg ? ST_WIN_PUSH : ST_SEL;
            ST_WIN_PUSH: state_next = ST_SEL;
            ST_SEL:
            begin
                if (!use_ma_reg)
                begin
                    state_next = ST_LP_D;
                end
                else if (fill_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!busy_x)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LP_D:     state_next = ST_LP_LO;
            ST_LP_LO:    state_next = ST_LP_HI;
            ST_LP_HI:    state_next = ST_LP_ADD;
            ST_LP_ADD:   state_next = ST_LP_OUT;
            ST_LP_OUT:   state_next = (ax_reg == AX_Z) ? ST_FINISH : ST_LP_D;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Controller: outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:     in_stall  = 1'b0;
            ST_WIN_RD:   ram_re    = 1'b1;
            ST_WIN_PUSH: ram_we    = 1'b1;
            ST_DIV_GO:   div_start = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode, window and filter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_NONE;
            button_reg   <= '0;
            raw_x_reg    <= '0;
            raw_y_reg    <= '0;
            raw_z_reg    <= '0;
            wheel_reg    <= '0;
            frame_reg    <= 1'b0;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            smooth_z_reg <= '0;
            push_reg     <= 1'b0;
            ax_reg       <= AX_X;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        kind_reg   <= kind_next;
                        button_reg <= button_next;
                        raw_x_reg  <= raw_x_next;
                        raw_y_reg  <= raw_y_next;
                        raw_z_reg  <= raw_z_next;
                        wheel_reg  <= wheel_next;
                        frame_reg  <= frame_next;
                    end
                end
                ST_START:
                begin
                    // A full window that still matches the target drops and appends.
                    push_reg <= (fill_reg == wsat);
                    ax_reg   <= AX_X;
                end
                ST_WIN_POP:
                begin
                    sum_x_reg  <= sum_x_reg - SW'($signed(ram_rdata[31:0]));
                    sum_y_reg  <= sum_y_reg - SW'($signed(ram_rdata[63:32]));
                    oldest_reg <= oldest_inc;
                    fill_reg   <= fill_reg - 1'b1;
                end
                ST_WIN_PUSH:
                begin
                    sum_x_reg <= sum_x_reg + SW'(raw_x_reg);
                    sum_y_reg <= sum_y_reg + SW'(raw_y_reg);
                    fill_reg  <= fill_reg + 1'b1;
                end
                ST_SEL:
                begin
                    if (use_ma_reg && (fill_reg == '0))
                    begin
                        smooth_x_reg <= $signed({raw_x_reg, 8'd0});
                        smooth_y_reg <= $signed({raw_y_reg, 8'd0});
                        smooth_z_reg <= '0;
                    end
                end
                ST_DIV_GO:
                begin
                    smooth_z_reg <= '0;
                end
                ST_DIV_WAIT:
                begin
                    if (!busy_x)
                    begin
                        smooth_x_reg <= neg_x_reg ? $signed(-qx40) : $signed(qx40);
                        smooth_y_reg <= neg_y_reg ? $signed(-qy40) : $signed(qy40);
                    end
                end
                ST_LP_OUT:
                begin
                    case (ax_reg)
                        AX_X:    smooth_x_reg <= lp_out;
                        AX_Y:    smooth_y_reg <= lp_out;
                        default: smooth_z_reg <= lp_out;
                    endcase
                    case (ax_reg)
                        AX_X:    ax_reg <= AX_Y;
                        AX_Y:    ax_reg <= AX_Z;
                        default: ax_reg <= AX_X;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIV_GO:
            begin
                neg_x_reg <= sum_x_reg[SW-1];
                neg_y_reg <= sum_y_reg[SW-1];
            end
            ST_LP_D:   d_reg   <= 41'(old_sel) - 41'(raw256);
            ST_LP_LO:  pl_reg  <= pl_next;
            ST_LP_HI:
            begin
                acc_reg <= $signed({17'd0, pl_reg});
                ph_reg  <= ph_next;
            end
            ST_LP_ADD: acc_reg <= acc_reg + $signed({ph_reg[33:0], 24'd0}) + 58'sd32768;
            default:   ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_kind_reg   <= kind_reg;
            out_button_reg <= button_reg;
            out_x_reg      <= raw_x_reg;
            out_y_reg      <= raw_y_reg;
            out_z_reg      <= raw_z_reg;
            out_wheel_reg  <= wheel_reg;
            out_sx_reg     <= smooth_x_reg;
            out_sy_reg     <= smooth_y_reg;
            out_sz_reg     <= smooth_z_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign button_state = out_button_reg;
    assign motion_x     = out_x_reg;
    assign motion_y     = out_y_reg;
    assign motion_z     = out_z_reg;
    assign wheel_motion = out_wheel_reg;
    assign smooth_x     = out_sx_reg;
    assign smooth_y     = out_sy_reg;
    assign smooth_z     = out_sz_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW_MAX))
        else $error("window fill above its capacity");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= IW'(WINDOW_MAX - 1))
        else $error("oldest pointer outside the window");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        busy_x == busy_y)
        else $error("dividers out of step");

    a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("report raised outside the finish step");

    a_pop_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIN_POP) |-> $past(state_reg == ST_WIN_RD))
        else $error("window pop without a preceding read");
`endif

endmodule

// ----- hdl/mef_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mef_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mef_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mef_div #(
    parameter int DW = 45,
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int NW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
